FILE: hdl/ppm_pkg.sv
// Shared constants and types for the projection profile mean block.
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int FRAC_BITS  = 8;

   localparam int PIXEL_W   = 8;
   localparam int SIZE_W    = 11;
   localparam int INDEX_W   = 10;
   localparam int MEAN_W    = 16;
   localparam int SUM_W     = 18;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int QUO_W     = PIXEL_W + FRAC_BITS;
   localparam int CFG_IDX_W = 2;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [MEAN_W-1:0] MEAN_MAX = MEAN_W'(255 << FRAC_BITS);

   typedef enum logic [CFG_IDX_W-1:0] {
      CFG_WIDTH  = 2'd0,
      CFG_HEIGHT = 2'd1,
      CFG_MODE   = 2'd2
   } cfg_index_type;

   typedef struct packed {
      logic [SUM_W-1:0]   sum;
      logic [SIZE_W-1:0]  divisor;
      logic [INDEX_W-1:0] index;
      logic               last;
   } job_type;

   typedef struct packed {
      logic                  head_valid;
      logic [FIFO_CNT_W-1:0] fill;
   } fifo_stat_type;

endpackage

`default_nettype wire

FILE: hdl/ppm_if.sv
// Handshake interfaces for the pixel, result and configuration channels.
`timescale 1ns / 1ps
`default_nettype none

interface ppm_req_if;
   logic                        valid;
   logic                        ready;
   logic [ppm_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface ppm_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ppm_pkg::MEAN_W-1:0]  profile_mean;
   logic [ppm_pkg::INDEX_W-1:0] profile_index;
   logic                        profile_last;

   modport source (output valid, output profile_mean, output profile_index,
                   output profile_last, input ready);
   modport sink   (input valid, input profile_mean, input profile_index,
                   input profile_last, output ready);
endinterface

interface ppm_csr_if;
   logic                          valid;
   logic                          ready;
   logic [ppm_pkg::CFG_IDX_W-1:0] index;
   logic [ppm_pkg::SIZE_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/ppm_fifo.sv
// Short job queue between the accumulating front end and the divider.
`timescale 1ns / 1ps
`default_nettype none

module ppm_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire ppm_pkg::job_type push_job,
   input  wire logic             pop,
   output ppm_pkg::job_type      head_job,
   output ppm_pkg::fifo_stat_type stat
);

   ppm_pkg::job_type                     mem [ppm_pkg::FIFO_DEPTH];
   logic [ppm_pkg::FIFO_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ppm_pkg::FIFO_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ppm_pkg::FIFO_CNT_W-1:0]       fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job        = mem[rd_ptr_ff];
   assign stat.head_valid = (fill_ff != '0);
   assign stat.fill       = fill_ff;

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff < ppm_pkg::FIFO_CNT_W'(ppm_pkg::FIFO_DEPTH)) || pop)
      else $error("job queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> fill_ff != '0)
      else $error("job queue read while empty");
`endif

endmodule

`default_nettype wire

FILE: hdl/ppm_front.sv
// Front end: configuration, raster position, row and column sums, job issue.
`timescale 1ns / 1ps
`default_nettype none

module ppm_front (
   input  wire logic              clock,
   input  wire logic              reset,
   ppm_req_if.sink                req_if,
   ppm_csr_if.sink                csr_if,
   input  wire ppm_pkg::fifo_stat_type stat,
   output logic                   push,
   output ppm_pkg::job_type       push_job
);

   localparam int SW = ppm_pkg::SIZE_W;

   // Configuration registers.
   logic [SW-1:0] width_ff, height_ff;
   logic          mode_ff;
   logic [SW-1:0] width_eff, height_eff;
   logic [ppm_pkg::COL_W-1:0] col_lastpos;
   logic [ppm_pkg::ROW_W-1:0] row_lastpos;

   // Raster position of the next word.
   logic [ppm_pkg::COL_W-1:0] col_ff, col_in;
   logic [ppm_pkg::ROW_W-1:0] row_ff, row_in;

   // Second stage: the word accepted in the previous cycle.
   logic                          b_valid_ff;
   logic [ppm_pkg::PIXEL_W-1:0]   b_pixel_ff;
   logic [ppm_pkg::COL_W-1:0]     b_col_ff;
   logic [ppm_pkg::ROW_W-1:0]     b_row_ff;
   logic                          b_col_last_ff, b_row_last_ff;
   logic                          b_byp_ff;
   logic [ppm_pkg::SUM_W-1:0]     fwd_sum_ff;
   logic [ppm_pkg::SUM_W-1:0]     rd_ff;
   logic [ppm_pkg::SUM_W-1:0]     row_acc_ff, row_acc_in;

   logic [ppm_pkg::SUM_W-1:0]     col_sums [ppm_pkg::MAX_WIDTH];

   logic                          accept, restart;
   logic [ppm_pkg::SUM_W-1:0]     col_base, col_sum, row_sum;
   logic [ppm_pkg::FIFO_CNT_W:0]  in_flight;

   always_comb begin
      if (width_ff == '0) begin
         width_eff = SW'(1);
      end else if (width_ff > SW'(ppm_pkg::MAX_WIDTH)) begin
         width_eff = SW'(ppm_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_ff;
      end
      if (height_ff == '0) begin
         height_eff = SW'(1);
      end else if (height_ff > SW'(ppm_pkg::MAX_HEIGHT)) begin
         height_eff = SW'(ppm_pkg::MAX_HEIGHT);
      end else begin
         height_eff = height_ff;
      end
   end

   assign col_lastpos = ppm_pkg::COL_W'(width_eff - 1'b1);
   assign row_lastpos = ppm_pkg::ROW_W'(height_eff - 1'b1);

   // Keep room in the queue for every word that may still issue a job.
   assign in_flight     = {1'b0, stat.fill} + {{ppm_pkg::FIFO_CNT_W{1'b0}}, b_valid_ff};
   assign req_if.ready  = in_flight < (ppm_pkg::FIFO_CNT_W + 1)'(ppm_pkg::FIFO_DEPTH);
   assign accept        = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;

   always_comb begin
      restart = 1'b0;
      if (csr_if.valid) begin
         case (csr_if.index)
            ppm_pkg::CFG_WIDTH, ppm_pkg::CFG_HEIGHT, ppm_pkg::CFG_MODE: begin
               restart = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == col_lastpos) begin
            col_in = '0;
            row_in = (row_ff == row_lastpos) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   // The line store read for a word overlaps the write of the word before it;
   // with a one-pixel-wide image both hit the same column and the new sum is
   // taken from the bypass register instead.
   assign col_base = b_byp_ff ? fwd_sum_ff : rd_ff;
   assign col_sum  = ((b_row_ff == '0) ? '0 : col_base)
                     + ppm_pkg::SUM_W'(b_pixel_ff);
   assign row_sum  = row_acc_ff + ppm_pkg::SUM_W'(b_pixel_ff);

   always_comb begin
      row_acc_in = row_acc_ff;
      if (restart) begin
         row_acc_in = '0;
      end else if (b_valid_ff && mode_ff) begin
         row_acc_in = b_col_last_ff ? '0 : row_sum;
      end
   end

   always_comb begin
      push_job = '0;
      if (mode_ff) begin
         push             = b_valid_ff && b_col_last_ff;
         push_job.sum     = row_sum;
         push_job.divisor = width_eff;
         push_job.index   = ppm_pkg::INDEX_W'(b_row_ff);
         push_job.last    = b_row_last_ff;
      end else begin
         push             = b_valid_ff && b_row_last_ff;
         push_job.sum     = col_sum;
         push_job.divisor = height_eff;
         push_job.index   = ppm_pkg::INDEX_W'(b_col_ff);
         push_job.last    = b_col_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= SW'(1024);
         height_ff  <= SW'(1024);
         mode_ff    <= 1'b1;
         col_ff     <= '0;
         row_ff     <= '0;
         row_acc_ff <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            case (csr_if.index)
               ppm_pkg::CFG_WIDTH:  width_ff  <= csr_if.data;
               ppm_pkg::CFG_HEIGHT: height_ff <= csr_if.data;
               ppm_pkg::CFG_MODE:   mode_ff   <= csr_if.data[0];
               default: begin
               end
            endcase
         end
         col_ff     <= col_in;
         row_ff     <= row_in;
         row_acc_ff <= row_acc_in;
         b_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_pixel_ff    <= req_if.pixel;
         b_col_ff      <= col_ff;
         b_row_ff      <= row_ff;
         b_col_last_ff <= (col_ff == col_lastpos);
         b_row_last_ff <= (row_ff == row_lastpos);
         b_byp_ff      <= b_valid_ff && (b_col_ff == col_ff);
         fwd_sum_ff    <= col_sum;
      end
   end

   // Line store of running column sums.
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= col_sums[col_ff];
      end
      if (b_valid_ff && !mode_ff) begin
         col_sums[b_col_ff] <= col_sum;
      end
   end

`ifndef NO_ASSERTIONS
   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= col_lastpos) && (row_ff <= row_lastpos))
      else $error("raster position outside the frame");
   a_restart: assert property (@(posedge clock) disable iff (reset)
      restart |=> (col_ff == '0) && (row_ff == '0) && (row_acc_ff == '0))
      else $error("register write did not restart the frame");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> stat.fill < ppm_pkg::FIFO_CNT_W'(ppm_pkg::FIFO_DEPTH))
      else $error("job issued with no room in the queue");
`endif

endmodule

`default_nettype wire

FILE: hdl/ppm_divider.sv
// Back end: pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module ppm_divider (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ppm_pkg::job_type       head_job,
   input  wire ppm_pkg::fifo_stat_type stat,
   output logic                        pop,
   ppm_rsp_if.source                   rsp_if
);

   localparam int QW     = ppm_pkg::QUO_W;
   localparam int RW     = ppm_pkg::SIZE_W;
   localparam int NUM_W  = ppm_pkg::SUM_W + ppm_pkg::FRAC_BITS;
   localparam int STAGES = QW;

   typedef struct packed {
      logic                        valid;
      logic [RW-1:0]               rem;
      logic [QW-1:0]               num;
      logic [QW-1:0]               quo;
      logic [ppm_pkg::SIZE_W-1:0]  divisor;
      logic [ppm_pkg::INDEX_W-1:0] index;
      logic                        last;
   } stage_type;

   // One restoring step: the remainder always stays below the divisor.
   function automatic stage_type div_step(input stage_type s);
      stage_type   r;
      logic [RW:0] trial;
      r     = s;
      trial = {s.rem, s.num[QW-1]};
      if (trial >= {1'b0, s.divisor}) begin
         r.rem = RW'(trial - {1'b0, s.divisor});
         r.quo = {s.quo[QW-2:0], 1'b1};
      end else begin
         r.rem = trial[RW-1:0];
         r.quo = {s.quo[QW-2:0], 1'b0};
      end
      r.num = {s.num[QW-2:0], 1'b0};
      return r;
   endfunction

   stage_type                   st_ff [STAGES];
   stage_type                   load;
   logic [NUM_W-1:0]            num_full;
   logic                        adv;
   logic                        out_valid_ff;
   logic [ppm_pkg::MEAN_W-1:0]  mean_ff;
   logic [ppm_pkg::INDEX_W-1:0] index_ff;
   logic                        last_ff;

   assign adv = !out_valid_ff || rsp_if.ready;
   assign pop = adv && stat.head_valid;

   always_comb begin
      num_full     = {head_job.sum, {ppm_pkg::FRAC_BITS{1'b0}}};
      load.valid   = stat.head_valid;
      load.rem     = RW'(num_full[NUM_W-1:QW]);
      load.num     = num_full[QW-1:0];
      load.quo     = '0;
      load.divisor = head_job.divisor;
      load.index   = head_job.index;
      load.last    = head_job.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) begin
            st_ff[k].valid <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         st_ff[0] <= div_step(load);
         for (int k = 1; k < STAGES; k++) begin
            st_ff[k] <= div_step(st_ff[k-1]);
         end
         out_valid_ff <= st_ff[STAGES-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && st_ff[STAGES-1].valid) begin
         mean_ff  <= ppm_pkg::MEAN_W'(st_ff[STAGES-1].quo);
         index_ff <= st_ff[STAGES-1].index;
         last_ff  <= st_ff[STAGES-1].last;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.profile_mean  = mean_ff;
   assign rsp_if.profile_index = index_ff;
   assign rsp_if.profile_last  = last_ff;

`ifndef NO_ASSERTIONS
   a_mean_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> mean_ff <= ppm_pkg::MEAN_MAX)
      else $error("mean above full scale");
   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(st_ff[STAGES-1].valid) && $stable(out_valid_ff))
      else $error("divider moved while the result was stalled");
`endif

endmodule

`default_nettype wire

FILE: hdl/projection_profile_mean.sv
// Top level of the projection profile mean block.
// Throughput: one pixel word per cycle in both modes while req_if.ready is high;
// the divider is fully pipelined.
// A stalled result stops the divider, then fills the four-entry job queue, then
// deasserts req_if.ready. Synchronous reset sets a 1024 by 1024 frame in row mode
// and clears all positions; the column line store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module projection_profile_mean (
   input  wire logic clock,
   input  wire logic reset,
   ppm_req_if.sink   req_if,
   ppm_rsp_if.source rsp_if,
   ppm_csr_if.sink   csr_if
);

   // The front end takes one pixel word per cycle while the queue has room, keeps
   // the raster position, accumulates the row sum or the column sums in the line
   // store, and issues a division job whenever a row or column is complete.
   logic                   push;
   ppm_pkg::job_type       push_job;
   ppm_pkg::job_type       head_job;
   ppm_pkg::fifo_stat_type stat;
   logic                   pop;

   ppm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .csr_if   (csr_if),
      .stat     (stat),
      .push     (push),
      .push_job (push_job)
   );

   // The queue decouples the two halves, so a stalled result does not stop
   // pixel intake until the queue, together with the word in the second stage, is full.
   ppm_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .stat     (stat)
   );

   // The back end divides the sum, shifted by the fraction bits, by the pixel
   // count of the row or column and holds the result in an output register.
   ppm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .stat     (stat),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule

`default_nettype wire
